[rtl/core/voxel_face_culler_unit_defines.svh]
// Assertion helpers shared by the RTL.
`ifndef VOXEL_FACE_CULLER_UNIT_DEFINES_SVH
`define VOXEL_FACE_CULLER_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on aclk, quiet during reset.
`define VFC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, quiet during reset.
`define VFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/vfc_pkg.sv]
`default_nettype none

package vfc_pkg;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EMIT
    } vfc_state_t;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CULL  = 1'b1;

    localparam int NUM_SIDES = 6;

    localparam logic [2:0] FACE_Z_LO = 3'd0;
    localparam logic [2:0] FACE_Z_HI = 3'd1;
    localparam logic [2:0] FACE_Y_LO = 3'd2;
    localparam logic [2:0] FACE_Y_HI = 3'd3;
    localparam logic [2:0] FACE_X_LO = 3'd4;
    localparam logic [2:0] FACE_X_HI = 3'd5;

    // Read sequence: center cell, then one neighbor per side.
    localparam logic [2:0] STEP_CENTER = 3'd0;
    localparam logic [2:0] STEP_LAST   = 3'd7;

    // Register index, taken from paddr[2].
    localparam logic REG_AIR_CODE = 1'b0;

endpackage

`default_nettype wire

[rtl/core/voxel_face_culler_unit.sv]
// Voxel hidden-face culler. Holds a cubic store of 8-bit block codes in one
// single-port synchronous RAM. A write word stores a code and gives no
// result. A cull word reads the cell and its six neighbors through the same
// RAM port, one read per cycle, then emits one result per exposed face
// (z-, z+, y-, y+, x-, x+), or a single face_valid=0 word when none is
// exposed; last_face marks the final word. A cull occupies the block
// through its serial RAM reads and its result words, plus any time the
// output stalls. No new word is taken while a result word waits on m_ready.
// After reset the RAM is cleared to zero, all 2^(3*clog2(CHUNK_EDGE))
// entries (4096 by default), during which s_ready stays low; air_code may
// be written at any time.
`default_nettype none

`include "voxel_face_culler_unit_defines.svh"

module voxel_face_culler_unit #(
    parameter int CHUNK_EDGE = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_command,
    input  wire logic [3:0]  s_cell_x,
    input  wire logic [3:0]  s_cell_y,
    input  wire logic [3:0]  s_cell_z,
    input  wire logic [7:0]  s_block_value,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_face_valid,
    output logic [3:0]       m_face_x,
    output logic [3:0]       m_face_y,
    output logic [3:0]       m_face_z,
    output logic [2:0]       m_face_side,
    output logic [7:0]       m_stored_code,
    output logic             m_last_face,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import vfc_pkg::*;

    localparam int CW    = $clog2(CHUNK_EDGE);
    localparam int AW    = 3 * CW;
    localparam int DEPTH = 1 << AW;

    // config
    logic [7:0] air_code_reg;
    logic       cfg_wr;

    // RAM
    logic [7:0]    mem [DEPTH];
    logic [7:0]    mem_rdata_reg;
    logic [AW-1:0] mem_addr;
    logic          mem_we;
    logic [7:0]    mem_wdata;

    // control
    vfc_state_t          state_reg, state_next;
    logic [2:0]          step_reg, step_next;
    logic [AW-1:0]       clr_addr_reg, clr_addr_next;
    logic [3:0]          x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic                inside_reg, inside_next;
    logic [7:0]          code_reg, code_next;
    logic [NUM_SIDES-1:0] exp_reg, exp_next;

    // output slot
    logic       m_valid_reg, m_valid_next;
    logic       face_valid_reg, face_valid_next;
    logic [2:0] face_side_reg, face_side_next;
    logic       last_face_reg, last_face_next;

    // datapath helpers
    logic                 s_inside;
    logic [AW-1:0]        s_addr;
    logic [CW-1:0]        cx, cy, cz;
    logic [AW-1:0]        rd_addr;
    logic [NUM_SIDES-1:0] bnd;
    logic [NUM_SIDES-1:0] eff_mask;
    logic [NUM_SIDES-1:0] sel_bit;
    logic [2:0]           sel_idx;
    logic                 slot_free;
    logic                 nb_air;

    // APB
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign prdata = (paddr[2] == REG_AIR_CODE) ? {24'd0, air_code_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            air_code_reg <= 8'd0;
        end else if (cfg_wr && paddr[2] == REG_AIR_CODE) begin
            air_code_reg <= pwdata[7:0];
        end
    end

    // address helpers
    assign s_inside = (32'(s_cell_x) < CHUNK_EDGE) && (32'(s_cell_y) < CHUNK_EDGE) &&
                      (32'(s_cell_z) < CHUNK_EDGE);
    assign s_addr   = {CW'(s_cell_x), CW'(s_cell_y), CW'(s_cell_z)};

    assign cx = CW'(x_reg);
    assign cy = CW'(y_reg);
    assign cz = CW'(z_reg);

    assign bnd[FACE_Z_LO] = (z_reg == 4'd0);
    assign bnd[FACE_Z_HI] = (32'(z_reg) >= CHUNK_EDGE - 1);
    assign bnd[FACE_Y_LO] = (y_reg == 4'd0);
    assign bnd[FACE_Y_HI] = (32'(y_reg) >= CHUNK_EDGE - 1);
    assign bnd[FACE_X_LO] = (x_reg == 4'd0);
    assign bnd[FACE_X_HI] = (32'(x_reg) >= CHUNK_EDGE - 1);

    always_comb begin
        unique case (step_reg)
            3'd1:    rd_addr = {cx, cy, cz - 1'b1};
            3'd2:    rd_addr = {cx, cy, cz + 1'b1};
            3'd3:    rd_addr = {cx, cy - 1'b1, cz};
            3'd4:    rd_addr = {cx, cy + 1'b1, cz};
            3'd5:    rd_addr = {cx - 1'b1, cy, cz};
            3'd6:    rd_addr = {cx + 1'b1, cy, cz};
            default: rd_addr = {cx, cy, cz};
        endcase
    end

    assign eff_mask  = exp_reg & {NUM_SIDES{code_reg != air_code_reg}};
    assign slot_free = !m_valid_reg || m_ready;
    assign nb_air    = (mem_rdata_reg == air_code_reg);

    always_comb begin
        sel_idx = FACE_Z_LO;
        for (int i = NUM_SIDES - 1; i >= 0; i--) begin
            if (eff_mask[i]) begin
                sel_idx = 3'(i);
            end
        end
    end
    assign sel_bit = NUM_SIDES'(1) << sel_idx;

    // RAM: one port, read data registered
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_addr];
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        step_next       = step_reg;
        clr_addr_next   = clr_addr_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        z_next          = z_reg;
        inside_next     = inside_reg;
        code_next       = code_reg;
        exp_next        = exp_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        face_valid_next = face_valid_reg;
        face_side_next  = face_side_reg;
        last_face_next  = last_face_reg;
        mem_addr        = rd_addr;
        mem_we          = 1'b0;
        mem_wdata       = s_block_value;
        s_ready         = 1'b0;

        unique case (state_reg)
            ST_CLEAR: begin
                mem_addr      = clr_addr_reg;
                mem_we        = 1'b1;
                mem_wdata     = 8'd0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (&clr_addr_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready  = slot_free;
                mem_addr = s_addr;
                if (s_valid && slot_free) begin
                    if (s_command == CMD_WRITE) begin
                        mem_we = s_inside;
                    end else begin
                        x_next      = s_cell_x;
                        y_next      = s_cell_y;
                        z_next      = s_cell_z;
                        inside_next = s_inside;
                        step_next   = STEP_CENTER;
                        state_next  = ST_READ;
                    end
                end
            end
            ST_READ: begin
                step_next = step_reg + 1'b1;
                if (step_reg == 3'd1) begin
                    code_next = inside_reg ? mem_rdata_reg : air_code_reg;
                end else if (step_reg != STEP_CENTER) begin
                    exp_next[3'(step_reg - 3'd2)] = bnd[3'(step_reg - 3'd2)] || nb_air;
                end
                if (step_reg == STEP_LAST) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    if (eff_mask == '0) begin
                        face_valid_next = 1'b0;
                        face_side_next  = FACE_Z_LO;
                        last_face_next  = 1'b1;
                        state_next      = ST_IDLE;
                    end else begin
                        face_valid_next = 1'b1;
                        face_side_next  = sel_idx;
                        exp_next        = exp_reg & ~sel_bit;
                        last_face_next  = ((eff_mask & ~sel_bit) == '0);
                        if ((eff_mask & ~sel_bit) == '0) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            step_reg     <= STEP_CENTER;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            step_reg     <= step_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg          <= x_next;
        y_reg          <= y_next;
        z_reg          <= z_next;
        inside_reg     <= inside_next;
        code_reg       <= code_next;
        exp_reg        <= exp_next;
        face_valid_reg <= face_valid_next;
        face_side_reg  <= face_side_next;
        last_face_reg  <= last_face_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_face_valid  = face_valid_reg;
    assign m_face_x      = x_reg;
    assign m_face_y      = y_reg;
    assign m_face_z      = z_reg;
    assign m_face_side   = face_side_reg;
    assign m_stored_code = code_reg;
    assign m_last_face   = last_face_reg;

    `VFC_ASSERT_NOW(a_no_accept_clear, state_reg == ST_CLEAR, !s_ready, "word accepted during clear")
    `VFC_ASSERT_NOW(a_no_write_in_read, state_reg == ST_READ, !mem_we, "RAM write during cull reads")
    `VFC_ASSERT_NEXT(a_cull_starts, s_valid && s_ready && s_command == CMD_CULL,
        state_reg == ST_READ && step_reg == STEP_CENTER, "cull did not start reads")
    `VFC_ASSERT_NOW(a_null_is_last, m_valid_reg && !face_valid_reg, last_face_reg,
        "empty result not marked last")
    `VFC_ASSERT_NEXT(a_emit_hold, m_valid_reg && !m_ready, m_valid_reg && $stable(face_side_reg),
        "stalled result changed")

endmodule

`default_nettype wire
